// ===== hdl/spq_pkg.sv =====
package spq_pkg;

  // Number of cells in the chain
  localparam int DEPTH = 16;
  // Width of the fill count, able to hold DEPTH itself
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int DATA_W = 32;
  localparam int PRIO_W = 32;
  localparam int COUNT_OUT_W = 5;

  // Command codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // One queue entry
  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

  // Operation broadcast to every cell in a cycle
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t ent;
  } cell_op_t;

endpackage

// ===== hdl/spq_cell.sv =====
module spq_cell (
  input  logic              clk,
  input  logic              rst,
  input  spq_pkg::cell_op_t op,
  input  logic              left_valid,
  input  logic              left_disp,
  input  spq_pkg::entry_t   left_entry,
  input  logic              right_valid,
  input  spq_pkg::entry_t   right_entry,
  output logic              valid,
  output logic              disp,
  output spq_pkg::entry_t   entry
);
  import spq_pkg::*;

  // New entry sorts strictly ahead of this one: this entry moves one slot back
  assign disp = valid && op.enq && (op.ent.prio < entry.prio);

  // Occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (op.deq) begin
      valid <= right_valid;
    end else if (op.enq && !valid && left_valid) begin
      valid <= 1'b1;
    end
  end

  // Entry payload: take the neighbor's entry on a shift, or the new one
  always_ff @(posedge clk) begin
    if (op.deq) begin
      entry <= right_entry;
    end else if (op.enq && (disp || (!valid && left_valid))) begin
      entry <= left_disp ? left_entry : op.ent;
    end
  end

endmodule

// ===== hdl/sorted_priority_queue.sv =====
// Sorted priority queue of DEPTH entries (data word and signed priority),
// served in ascending priority number, first in first out among equal
// priorities. Each command (start high while busy is low) is handled by a
// chain of DEPTH cells that compare against the new entry in parallel
// and shift by one slot, so a command is taken every cycle and busy
// never rises. The result appears on data_out, status and
// entry_count in the cycle after the command, for exactly one cycle, marked
// by done; it must be captured then, since the receiver cannot hold it off.
// Enqueue on a full queue drops the entry with status full; dequeue on an
// empty queue returns zero with status empty. No clearing pass after reset.
module sorted_priority_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic signed [spq_pkg::DATA_W-1:0] data_in,
  input  logic signed [spq_pkg::PRIO_W-1:0] priority_in,
  output logic        done,
  output logic signed [spq_pkg::DATA_W-1:0] data_out,
  output logic [1:0]  status,
  output logic [spq_pkg::COUNT_OUT_W-1:0] entry_count
);
  import spq_pkg::*;

  logic             accept;
  logic             full;
  logic             empty;
  cell_op_t         op;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [DEPTH-1:0] vld;
  logic [DEPTH-1:0] dsp;
  entry_t           ent [DEPTH];

  // Commands never stall, so busy is tied low
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = vld[DEPTH-1];
  assign empty  = !vld[0];

  // Broadcast operation, gated by full and empty
  assign op.enq = accept && (command == CMD_ENQ) && !full;
  assign op.deq = accept && (command == CMD_DEQ) && !empty;
  assign op.ent = '{data: data_in, prio: priority_in};

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   lv;
    logic   ld;
    entry_t le;
    logic   rv;
    entry_t re;

    if (i == 0) begin : g_head
      assign lv = 1'b1;
      assign ld = 1'b0;
      assign le = '0;
    end else begin : g_mid
      assign lv = vld[i-1];
      assign ld = dsp[i-1];
      assign le = ent[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rv = 1'b0;
      assign re = '0;
    end else begin : g_body
      assign rv = vld[i+1];
      assign re = ent[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .op          (op),
      .left_valid  (lv),
      .left_disp   (ld),
      .left_entry  (le),
      .right_valid (rv),
      .right_entry (re),
      .valid       (vld[i]),
      .disp        (dsp[i]),
      .entry       (ent[i])
    );
  end

  // Fill count
  always_comb begin
    count_next = count;
    if (op.enq) begin
      count_next = count + CNT_W'(1);
    end else if (op.deq) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      data_out    <= op.deq ? ent[0].data : '0;
      entry_count <= COUNT_OUT_W'(count_next);
      if (command == CMD_ENQ) begin
        status <= full ? ST_FULL : ST_OK;
      end else begin
        status <= empty ? ST_EMPTY : ST_OK;
      end
    end
  end

  // Occupied cells form a contiguous run from the head
  a_vld_contig: assert property (@(posedge clk) disable iff (rst)
    ((vld + DEPTH'(1)) & vld) == '0)
    else $error("occupied cells not contiguous");

  // Fill count tracks the occupied cells
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    $countones(vld) == int'(count))
    else $error("fill count disagrees with cells");

  // Every accepted command yields one result in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("missing result");

  // Empty status leaves the queue empty
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_EMPTY)) |-> (entry_count == '0 && data_out == '0))
    else $error("empty result with entries or data");

endmodule
